// ===== rtl/jmsc_pkg.sv =====
// shared types, marker codes and the parser state record for the marker stream checker
package jmsc_pkg;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_SKIP   = 3'd4
  } phase_e;

  localparam logic [7:0] MK_PREFIX   = 8'hFF;
  localparam logic [7:0] MK_STUFF    = 8'h00;
  localparam logic [7:0] MK_APP_LO   = 8'hE0;
  localparam logic [7:0] MK_APP_HI   = 8'hE9;
  localparam logic [7:0] MK_RST_LO   = 8'hD0;
  localparam logic [7:0] MK_RST_HI   = 8'hD7;
  localparam logic [7:0] MK_EOI      = 8'hD9;
  localparam logic [7:0] MK_SOF0     = 8'hC0;
  localparam logic [7:0] MK_SOF2     = 8'hC2;
  localparam logic [7:0] MK_DHT      = 8'hC4;
  localparam logic [7:0] MK_DQT      = 8'hDB;
  localparam logic [7:0] MK_COM      = 8'hFE;
  localparam logic [7:0] MK_SOS      = 8'hDA;
  localparam logic [7:0] MK_DRI      = 8'hDD;

  localparam logic [15:0] DRI_BODY_LEN = 16'd4;
  localparam logic [15:0] LEN_MIN      = 16'd2;

  typedef struct packed {
    phase_e      phase;
    logic        in_scan;
    logic [7:0]  len_hi;
    logic [15:0] skip;
    logic        enter_scan;
    logic        err;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:      PH_PREFIX,
    in_scan:    1'b0,
    len_hi:     8'h00,
    skip:       16'h0000,
    enter_scan: 1'b0,
    err:        1'b0
  };

endpackage

// ===== rtl/jmsc_parse.sv =====
// next-state logic of the marker parser for one byte
module jmsc_parse
  import jmsc_pkg::*;
(
  input  parse_state_t state_i,
  input  logic [7:0]   byte_i,
  output parse_state_t state_o,
  output logic         pass_o
);

  logic        len_code;
  logic        rst_code;
  logic        bare_code;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  parse_state_t st;

  assign len_code = ((byte_i >= MK_APP_LO) && (byte_i <= MK_APP_HI)) ||
                    (byte_i == MK_SOF0) || (byte_i == MK_SOF2) ||
                    (byte_i == MK_DHT) || (byte_i == MK_DQT) || (byte_i == MK_COM);
  assign rst_code  = (byte_i >= MK_RST_LO) && (byte_i <= MK_RST_HI);
  assign bare_code = (byte_i >= MK_RST_LO) && (byte_i <= MK_EOI);
  assign seg_len   = {state_i.len_hi, byte_i};
  assign skip_dec  = (state_i.skip != 16'd0) ? (state_i.skip - 16'd1) : state_i.skip;

  always_comb begin
    st = state_i;
    if (!state_i.err) begin
      unique case (state_i.phase)
        PH_PREFIX: begin
          if (byte_i == MK_PREFIX) begin
            st.phase = PH_CODE;
          end else if (!state_i.in_scan) begin
            st.err = 1'b1;
          end
        end
        PH_CODE: begin
          // stuffing, fill bytes and restarts stay inside scan data
          if (state_i.in_scan && (byte_i == MK_STUFF || rst_code)) begin
            st.phase = PH_PREFIX;
          end else if (state_i.in_scan && byte_i == MK_PREFIX) begin
            st.phase = PH_CODE;
          end else begin
            st.in_scan = 1'b0;
            priority if (len_code) begin
              st.enter_scan = 1'b0;
              st.phase      = PH_LEN_HI;
            end else if (byte_i == MK_SOS) begin
              st.enter_scan = 1'b1;
              st.phase      = PH_LEN_HI;
            end else if (bare_code) begin
              st.phase = PH_PREFIX;
            end else if (byte_i == MK_DRI) begin
              st.enter_scan = 1'b0;
              st.skip       = DRI_BODY_LEN;
              st.phase      = PH_SKIP;
            end else begin
              st.err = 1'b1;
            end
          end
        end
        PH_LEN_HI: begin
          st.len_hi = byte_i;
          st.phase  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < LEN_MIN) begin
            st.err = 1'b1;
          end else begin
            st.skip = seg_len - LEN_MIN;
            if (seg_len == LEN_MIN) begin
              st.phase      = PH_PREFIX;
              st.in_scan    = state_i.enter_scan;
              st.enter_scan = 1'b0;
            end else begin
              st.phase = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          st.skip = skip_dec;
          if (skip_dec == 16'd0) begin
            st.phase      = PH_PREFIX;
            st.in_scan    = state_i.enter_scan;
            st.enter_scan = 1'b0;
          end
        end
        default: begin
          st.err = 1'b1;
        end
      endcase
    end
  end

  assign state_o = st;
  assign pass_o  = !st.err && (st.phase != PH_CODE) && (st.phase != PH_LEN_HI) &&
                   (st.phase != PH_LEN_LO);

endmodule

// ===== rtl/jpeg_marker_stream_check.sv =====
// top level: input register, parser state, verdict register
// Checks the marker structure of a JPEG file fed one byte per item and gives one
// pass/fail item for the byte flagged with tlast. One byte is taken every cycle
// when the verdict side keeps up; only a byte with tlast waits while an earlier
// verdict has not been taken. A verdict is loaded into the verdict register when its
// last byte leaves the input register; the byte is held there while the parser
// decodes it. The parser state update and the verdict register load happen at the
// same edge, through one combinational path over the marker decode and the 16-bit
// length and skip counter. The parser returns to its reset state after every verdict.
module jpeg_marker_stream_check
  import jmsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] file_valid, [7:1] zero
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         out_valid_q, out_valid_d;
  logic         out_pass_q;
  logic         advance;
  logic         take_in;
  logic         step_pass;
  parse_state_t state_q, state_d, step_state;

  jmsc_parse u_parse (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (step_state),
    .pass_o  (step_pass)
  );

  // a last byte moves on only if the verdict slot is free or being emptied
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign take_in = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take_in) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = in_last_q ? STATE_RESET : step_state;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance && in_last_q) begin
      out_pass_q <= step_pass;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_pass_q};

  a_reset_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> state_q == STATE_RESET)
    else $error("parser state not cleared after verdict");

  a_verdict_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> out_valid_q)
    else $error("verdict not presented after last byte");

  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && in_last_q))
    else $error("verdict appeared without a last byte");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.err && !(advance && in_last_q) |=> state_q.err)
    else $error("error flag dropped inside a file");

endmodule
